FILE: src/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared types, constants and CORDIC helpers for the compass pipeline
// Fixed-point formats, the arctangent table and the per-iteration step
// functions that the pipeline stages of the top level apply.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // field widths
    localparam int ANGLE_BITS  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 2;

    // stream payload widths, padded to whole bytes
    localparam int DIN_W  = ((6 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int DOUT_W = ((3 * ANGLE_BITS + 7) / 8) * 8;

    // cordic setup
    localparam int CORDIC_N  = 28;
    localparam int ACC_SHIFT = 12;
    localparam int FLD_SHIFT = 4;
    localparam int VW        = SAMPLE_BITS + ACC_SHIFT + 4;
    localparam int RW        = SAMPLE_BITS + FLD_SHIFT + 4;

    // inverse cordic gain, split into two partial products
    localparam int INV_GAIN   = 652032874;
    localparam int GAIN_SPLIT = 15;
    localparam int GAIN_SHIFT = 30;
    localparam int GAIN_HI    = INV_GAIN >> GAIN_SPLIT;
    localparam int GAIN_LO    = INV_GAIN & ((1 << GAIN_SPLIT) - 1);
    localparam int PW         = RW + GAIN_SPLIT + 2;
    localparam int SW         = PW + GAIN_SPLIT + 2;

    // square and compare widths
    localparam int MSQ_W  = 2 * SAMPLE_BITS + 2;
    localparam int ASQ_W  = 2 * ANGLE_BITS;
    localparam int CMP_A  = (MSQ_W > ASQ_W + 1) ? MSQ_W : ASQ_W + 1;
    localparam int CMP_W  = ((CMP_A > CFG_W) ? CMP_A : CFG_W) + 1;

    // pipeline depth: front 3, four cordic runs of N+1, two tilt, two gain twice, output
    localparam int DEPTH = 4 * CORDIC_N + 14;

    // register defaults
    localparam logic [CFG_W-1:0] MAG_MIN_RST    = 32'd4194304;
    localparam logic [CFG_W-1:0] MAG_MAX_RST    = 32'd9437184;
    localparam logic [CFG_W-1:0] TILT_LIMIT_RST = 32'd29822521;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] ATAN_TAB [CORDIC_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAG_MIN    = 2'd0,
        REG_MAG_MAX    = 2'd1,
        REG_TILT_LIMIT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MAG_RANGE = 2'd1,
        ST_TILT      = 2'd2
    } status_t;

    typedef logic signed [SAMPLE_BITS-1:0]   sample_t;
    typedef logic signed [ANGLE_BITS-1:0]    angle_t;
    typedef logic signed [2*SAMPLE_BITS-1:0] sq_t;
    typedef logic signed [ASQ_W-1:0]         asq_t;
    typedef logic signed [VW-1:0]            vw_t;
    typedef logic signed [RW-1:0]            rw_t;

    typedef struct packed {
        sample_t ax;
        sample_t ay;
        sample_t az;
        sample_t mx;
        sample_t my;
        sample_t mz;
    } smp_t;

    // vectoring cordic state
    typedef struct packed {
        vw_t         x;
        vw_t         y;
        logic [31:0] z;
        logic        zero;
    } vec_t;

    // rotation cordic state
    typedef struct packed {
        rw_t                x;
        rw_t                y;
        logic signed [31:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
    } gp_t;

    // side data carried beside the cordic runs
    typedef struct packed {
        logic    fail;
        sample_t mx;
        sample_t my;
        sample_t mz;
    } side_a_t;

    typedef struct packed {
        logic    fail;
        logic    tilt;
        angle_t  pitch;
        angle_t  roll;
        sample_t mx;
    } side_b_t;

    typedef struct packed {
        logic   fail;
        logic   tilt;
        angle_t pitch;
        angle_t roll;
        rw_t    proj_y;
    } side_c_t;

    typedef struct packed {
        logic   fail;
        logic   tilt;
        angle_t pitch;
        angle_t roll;
    } side_d_t;

    function automatic vw_t scale_acc(input sample_t a);
        return vw_t'(a) <<< ACC_SHIFT;
    endfunction

    function automatic rw_t scale_fld(input sample_t a);
        return rw_t'(a) <<< FLD_SHIFT;
    endfunction

    // fold into the right half plane, flag the zero vector
    function automatic vec_t vec_init(input vw_t x, input vw_t y);
        vec_t r;
        r.zero = (x == '0) && (y == '0);
        if (x[VW-1]) begin
            r.x = -x;
            r.y = -y;
            r.z = 32'h8000_0000;
        end else begin
            r.x = x;
            r.y = y;
            r.z = '0;
        end
        return r;
    endfunction

    // one vectoring iteration, drives y toward zero
    function automatic vec_t vec_step(input vec_t a, input int i);
        vec_t r;
        r = a;
        if (!a.y[VW-1]) begin
            r.x = a.x + (a.y >>> i);
            r.y = a.y - (a.x >>> i);
            r.z = a.z + ATAN_TAB[i];
        end else begin
            r.x = a.x - (a.y >>> i);
            r.y = a.y + (a.x >>> i);
            r.z = a.z - ATAN_TAB[i];
        end
        return r;
    endfunction

    // fold the angle into [-pi/2, pi/2]
    function automatic rot_t rot_init(input rw_t x, input rw_t y, input logic [31:0] th);
        rot_t               r;
        logic signed [31:0] z;
        z = signed'(th);
        if (z > 32'sd1073741824 || z < -32'sd1073741824) begin
            r.x = -x;
            r.y = -y;
            r.z = {~z[31], z[30:0]};
        end else begin
            r.x = x;
            r.y = y;
            r.z = z;
        end
        return r;
    endfunction

    // one rotation iteration, drives z toward zero
    function automatic rot_t rot_step(input rot_t a, input int i);
        rot_t r;
        r = a;
        if (!a.z[31]) begin
            r.x = a.x - (a.y >>> i);
            r.y = a.y + (a.x >>> i);
            r.z = a.z - signed'(ATAN_TAB[i]);
        end else begin
            r.x = a.x + (a.y >>> i);
            r.y = a.y - (a.x >>> i);
            r.z = a.z + signed'(ATAN_TAB[i]);
        end
        return r;
    endfunction

    // round half up to the output angle width
    function automatic angle_t quant_angle(input logic [31:0] z);
        logic [31:0] r;
        r = z + (32'd1 << (31 - ANGLE_BITS));
        return r[31 -: ANGLE_BITS];
    endfunction

    function automatic logic [31:0] wide_angle(input angle_t a);
        return {a, {(32 - ANGLE_BITS){1'b0}}};
    endfunction

    // gain compensation, first half: two partial products
    function automatic gp_t gain_mul(input rw_t v);
        gp_t p;
        p.hi = PW'(v) * PW'(GAIN_HI);
        p.lo = PW'(v) * PW'(GAIN_LO);
        return p;
    endfunction

    // gain compensation, second half: sum, round, floor shift
    function automatic rw_t gain_sum(input gp_t p);
        logic signed [SW-1:0] s;
        s = (SW'(p.hi) <<< GAIN_SPLIT) + SW'(p.lo) + (SW'(1) <<< (GAIN_SHIFT - 1));
        return rw_t'(s >>> GAIN_SHIFT);
    endfunction

endpackage

FILE: src/tilt_compensated_compass_top.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass_top: pipelined tilt-compensated compass
// Magnitude window, pitch and roll by vectoring cordic, tilt check, two
// rotations of the field vector and a heading vectoring cordic.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// s_        in         s_tvalid / s_tready    s_tdata: accel xyz, field xyz
// m_        out        m_tvalid / m_tready    m_tdata: heading, pitch, roll;
//                                             m_tuser: status
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transfer per cycle in, one per cycle out while m_ is not stalled; the pipeline holds
// four 28-stage cordic runs and the gain multipliers between them.
// aresetn (synchronous) clears all valid bits and loads the register defaults.
// a stall on m_ holds the whole pipeline and drops s_tready in the same cycle.
// cfg_ready is always high.
module tilt_compensated_compass_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // accel_x, accel_y, accel_z, field_x, field_y, field_z (lowest first)
    input  logic [tcc_pkg::DIN_W-1:0]      s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // heading, pitch_angle, roll_angle (lowest first)
    output logic [tcc_pkg::DOUT_W-1:0]     m_tdata,
    // status
    output logic [1:0]                     m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcc_pkg::CFG_W-1:0]      cfg_data
);
    import tcc_pkg::*;

    localparam int N = CORDIC_N;

    logic             adv;
    logic [DEPTH-1:0] vld_reg;

    logic [CFG_W-1:0] mag_min_reg;
    logic [CFG_W-1:0] mag_max_reg;
    logic [CFG_W-1:0] tilt_limit_reg;

    smp_t             f0_smp_reg;
    smp_t             f1_smp_reg;
    sq_t              f1_sq_reg [3];
    smp_t             f2_smp_reg;
    logic [MSQ_W-1:0] f2_msq_reg;

    vec_t             pr_p_reg    [N+1];
    vec_t             pr_r_reg    [N+1];
    side_a_t          pr_side_reg [N+1];

    angle_t           t0_pitch_reg;
    angle_t           t0_roll_reg;
    side_a_t          t0_side_reg;
    logic [ASQ_W-1:0] t1_pp_reg;
    logic [ASQ_W-1:0] t1_rr_reg;
    angle_t           t1_pitch_reg;
    angle_t           t1_roll_reg;
    side_a_t          t1_side_reg;

    rot_t             r1_reg      [N+1];
    side_b_t          r1_side_reg [N+1];
    gp_t              g1_px_reg;
    gp_t              g1_py_reg;
    side_b_t          g1a_side_reg;
    rw_t              g1_projy_reg;
    rw_t              g1_zt_reg;
    side_b_t          g1b_side_reg;

    rot_t             r2_reg      [N+1];
    side_c_t          r2_side_reg [N+1];
    gp_t              g2_px_reg;
    side_c_t          g2a_side_reg;
    rw_t              g2_xx_reg;
    side_c_t          g2b_side_reg;

    vec_t             hv_reg      [N+1];
    side_d_t          hv_side_reg [N+1];

    angle_t           out_heading_reg;
    angle_t           out_pitch_reg;
    angle_t           out_roll_reg;
    status_t          out_status_reg;

    angle_t           head;

    // global advance: the pipeline moves unless the output is stalled
    assign adv      = ~vld_reg[DEPTH-1] | m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[DEPTH-1];
    assign m_tdata  = DOUT_W'({out_roll_reg, out_pitch_reg, out_heading_reg});
    assign m_tuser  = out_status_reg;
    assign cfg_ready = 1'b1;

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_min_reg    <= MAG_MIN_RST;
            mag_max_reg    <= MAG_MAX_RST;
            tilt_limit_reg <= TILT_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAG_MIN:    mag_min_reg    <= cfg_data;
                REG_MAG_MAX:    mag_max_reg    <= cfg_data;
                REG_TILT_LIMIT: tilt_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: capture, squares, magnitude sum
    always_ff @(posedge aclk) begin
        if (adv) begin
            f0_smp_reg.ax <= s_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
            f0_smp_reg.ay <= s_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
            f0_smp_reg.az <= s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
            f0_smp_reg.mx <= s_tdata[3*SAMPLE_BITS +: SAMPLE_BITS];
            f0_smp_reg.my <= s_tdata[4*SAMPLE_BITS +: SAMPLE_BITS];
            f0_smp_reg.mz <= s_tdata[5*SAMPLE_BITS +: SAMPLE_BITS];

            f1_smp_reg   <= f0_smp_reg;
            f1_sq_reg[0] <= sq_t'(f0_smp_reg.ax) * sq_t'(f0_smp_reg.ax);
            f1_sq_reg[1] <= sq_t'(f0_smp_reg.ay) * sq_t'(f0_smp_reg.ay);
            f1_sq_reg[2] <= sq_t'(f0_smp_reg.az) * sq_t'(f0_smp_reg.az);

            f2_smp_reg <= f1_smp_reg;
            f2_msq_reg <= MSQ_W'(f1_sq_reg[0]) + MSQ_W'(f1_sq_reg[1])
                        + MSQ_W'(f1_sq_reg[2]);
        end
    end

    // window check and pitch/roll vectoring setup
    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_side_reg[0].fail <= (CMP_W'(f2_msq_reg) < CMP_W'(mag_min_reg))
                                || (CMP_W'(f2_msq_reg) > CMP_W'(mag_max_reg));
            pr_side_reg[0].mx <= f2_smp_reg.mx;
            pr_side_reg[0].my <= f2_smp_reg.my;
            pr_side_reg[0].mz <= f2_smp_reg.mz;
            pr_p_reg[0] <= vec_init(-scale_acc(f2_smp_reg.az), scale_acc(f2_smp_reg.ax));
            pr_r_reg[0] <= vec_init(-scale_acc(f2_smp_reg.az), -scale_acc(f2_smp_reg.ay));
        end
    end

    // pitch and roll cordic, one iteration per stage
    for (genvar k = 0; k < N; k++) begin : g_pr
        always_ff @(posedge aclk) begin
            if (adv) begin
                pr_p_reg[k+1]    <= vec_step(pr_p_reg[k], k);
                pr_r_reg[k+1]    <= vec_step(pr_r_reg[k], k);
                pr_side_reg[k+1] <= pr_side_reg[k];
            end
        end
    end

    // round angles, square them
    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_pitch_reg <= quant_angle(pr_p_reg[N].zero ? '0 : pr_p_reg[N].z);
            t0_roll_reg  <= quant_angle(pr_r_reg[N].zero ? '0 : pr_r_reg[N].z);
            t0_side_reg  <= pr_side_reg[N];

            t1_pp_reg    <= asq_t'(t0_pitch_reg) * asq_t'(t0_pitch_reg);
            t1_rr_reg    <= asq_t'(t0_roll_reg) * asq_t'(t0_roll_reg);
            t1_pitch_reg <= t0_pitch_reg;
            t1_roll_reg  <= t0_roll_reg;
            t1_side_reg  <= t0_side_reg;
        end
    end

    // tilt check and roll rotation setup
    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_side_reg[0].fail  <= t1_side_reg.fail;
            r1_side_reg[0].tilt  <= (CMP_W'(t1_pp_reg) + CMP_W'(t1_rr_reg))
                                 >= CMP_W'(tilt_limit_reg);
            r1_side_reg[0].pitch <= t1_pitch_reg;
            r1_side_reg[0].roll  <= t1_roll_reg;
            r1_side_reg[0].mx    <= t1_side_reg.mx;
            r1_reg[0] <= rot_init(scale_fld(t1_side_reg.my), scale_fld(t1_side_reg.mz),
                                  32'd0 - wide_angle(t1_roll_reg));
        end
    end

    // roll rotation
    for (genvar k = 0; k < N; k++) begin : g_r1
        always_ff @(posedge aclk) begin
            if (adv) begin
                r1_reg[k+1]      <= rot_step(r1_reg[k], k);
                r1_side_reg[k+1] <= r1_side_reg[k];
            end
        end
    end

    // gain compensation after roll rotation, then pitch rotation setup
    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_px_reg    <= gain_mul(r1_reg[N].x);
            g1_py_reg    <= gain_mul(r1_reg[N].y);
            g1a_side_reg <= r1_side_reg[N];

            g1_projy_reg <= gain_sum(g1_px_reg);
            g1_zt_reg    <= gain_sum(g1_py_reg);
            g1b_side_reg <= g1a_side_reg;

            r2_side_reg[0].fail   <= g1b_side_reg.fail;
            r2_side_reg[0].tilt   <= g1b_side_reg.tilt;
            r2_side_reg[0].pitch  <= g1b_side_reg.pitch;
            r2_side_reg[0].roll   <= g1b_side_reg.roll;
            r2_side_reg[0].proj_y <= g1_projy_reg;
            r2_reg[0] <= rot_init(scale_fld(g1b_side_reg.mx), g1_zt_reg,
                                  wide_angle(g1b_side_reg.pitch));
        end
    end

    // pitch rotation
    for (genvar k = 0; k < N; k++) begin : g_r2
        always_ff @(posedge aclk) begin
            if (adv) begin
                r2_reg[k+1]      <= rot_step(r2_reg[k], k);
                r2_side_reg[k+1] <= r2_side_reg[k];
            end
        end
    end

    // gain compensation of projected x, heading vectoring setup
    always_ff @(posedge aclk) begin
        if (adv) begin
            g2_px_reg    <= gain_mul(r2_reg[N].x);
            g2a_side_reg <= r2_side_reg[N];

            g2_xx_reg    <= gain_sum(g2_px_reg);
            g2b_side_reg <= g2a_side_reg;

            hv_side_reg[0].fail  <= g2b_side_reg.fail;
            hv_side_reg[0].tilt  <= g2b_side_reg.tilt;
            hv_side_reg[0].pitch <= g2b_side_reg.pitch;
            hv_side_reg[0].roll  <= g2b_side_reg.roll;
            hv_reg[0] <= vec_init(vw_t'(g2_xx_reg), vw_t'(g2b_side_reg.proj_y));
        end
    end

    // heading cordic
    for (genvar k = 0; k < N; k++) begin : g_hv
        always_ff @(posedge aclk) begin
            if (adv) begin
                hv_reg[k+1]      <= vec_step(hv_reg[k], k);
                hv_side_reg[k+1] <= hv_side_reg[k];
            end
        end
    end

    assign head = quant_angle(hv_reg[N].zero ? '0 : hv_reg[N].z);

    // output register: status and zeroing of refused results
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (hv_side_reg[N].fail) begin
                out_status_reg  <= ST_MAG_RANGE;
                out_heading_reg <= '0;
                out_pitch_reg   <= '0;
                out_roll_reg    <= '0;
            end else if (hv_side_reg[N].tilt) begin
                out_status_reg  <= ST_TILT;
                out_heading_reg <= '0;
                out_pitch_reg   <= hv_side_reg[N].pitch;
                out_roll_reg    <= hv_side_reg[N].roll;
            end else begin
                out_status_reg  <= ST_OK;
                out_heading_reg <= -head;
                out_pitch_reg   <= hv_side_reg[N].pitch;
                out_roll_reg    <= hv_side_reg[N].roll;
            end
        end
    end

    // a held result stalls the input side too
    a_stall_backs_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // magnitude failure zeroes every angle
    a_mag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_MAG_RANGE |-> m_tdata == '0)
        else $error("angles not zero on magnitude failure");

    // refused tilt zeroes the heading
    a_tilt_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_TILT |-> m_tdata[ANGLE_BITS-1:0] == '0)
        else $error("heading not zero on refused tilt");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

FILE: test/tb_tilt_compensated_compass_top.sv
// ----------------------------------------------------------------------------
// tb_tilt_compensated_compass_top: self-checking bench for the compass pipeline
// Streams accelerometer and magnetometer samples under random idling on both
// sides and across several register settings. Each result is compared
// field by field with a bit-exact cordic predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_compass_top;
    import tcc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint RECIP_GAIN = 64'sd652032874;

    typedef struct {
        angle_t  heading;
        angle_t  pitch;
        angle_t  roll;
        status_t status;
    } compass_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic [DIN_W-1:0]       s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DOUT_W-1:0]      m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    tilt_compensated_compass_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // bench copy of the window and tilt registers
    logic [31:0] mag_min;
    logic [31:0] mag_max;
    logic [31:0] tilt_limit;

    smp_t            pending_samples[$];
    compass_result_t compass_expected[$];
    smp_t            sample_on_bus;
    int              send_gap;
    int              out_stall;
    bit              send_burst;
    bit              recv_burst;
    int              sent_count;
    int              checked_count;
    int              error_count;
    int              setting_count;
    int              idle_cycles;

    // clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // ---------------- predictor ----------------

    // vectoring cordic: angle of (x, y), 2^32 per turn
    function automatic logic [31:0] vector_angle(input longint x0, input longint y0);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        x = x0;
        y = y0;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += ATAN_TAB[i];
            end else begin
                x -= dx;
                y += dy;
                z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    // round half up to the output angle width
    function automatic angle_t round_angle(input logic [31:0] z);
        logic [31:0] r;
        r = z + (32'd1 << (31 - ANGLE_BITS));
        return angle_t'(r[31 -: ANGLE_BITS]);
    endfunction

    // rotation cordic by angle th, then gain correction
    function automatic void rotate_vec(inout longint x, inout longint y,
                                       input logic [31:0] th);
        longint rx;
        longint ry;
        longint z;
        longint dx;
        longint dy;
        rx = x;
        ry = y;
        z = longint'(signed'(th));
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            rx = -rx;
            ry = -ry;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            rx = -rx;
            ry = -ry;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = ry >>> i;
            dy = rx >>> i;
            if (z >= 0) begin
                rx -= dx;
                ry += dy;
                z -= longint'(ATAN_TAB[i]);
            end else begin
                rx += dx;
                ry -= dy;
                z += longint'(ATAN_TAB[i]);
            end
        end
        x = (rx * RECIP_GAIN + (64'sd1 <<< 29)) >>> 30;
        y = (ry * RECIP_GAIN + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic compass_result_t predict_heading(input smp_t s);
        compass_result_t res;
        longint ax, ay, az, mx, my, mz;
        longint msq, p, r, yy, zt, xx, spare;
        angle_t head;
        ax = s.ax; ay = s.ay; az = s.az;
        mx = s.mx; my = s.my; mz = s.mz;
        res.heading = '0;
        res.pitch = '0;
        res.roll = '0;
        res.status = ST_OK;
        msq = ax * ax + ay * ay + az * az;
        if (msq < longint'(mag_min) || msq > longint'(mag_max)) begin
            res.status = ST_MAG_RANGE;
            return res;
        end
        res.pitch = round_angle(vector_angle(-az * 4096, ax * 4096));
        res.roll = round_angle(vector_angle(-az * 4096, -ay * 4096));
        p = res.pitch;
        r = res.roll;
        if (p * p + r * r >= longint'(tilt_limit)) begin
            res.status = ST_TILT;
            return res;
        end
        // bring the field vector back to the horizontal plane
        yy = my * 16;
        zt = mz * 16;
        rotate_vec(yy, zt, 32'd0 - {res.roll, {(32 - ANGLE_BITS){1'b0}}});
        xx = mx * 16;
        spare = zt;
        rotate_vec(xx, spare, {res.pitch, {(32 - ANGLE_BITS){1'b0}}});
        head = round_angle(vector_angle(xx, yy));
        res.heading = -head;
        return res;
    endfunction

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                compass_expected.push_back(predict_heading(sample_on_bus));
                sent_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    sample_on_bus = pending_samples.pop_front();
                    s_tdata <= {sample_on_bus.mz, sample_on_bus.my, sample_on_bus.mx,
                                sample_on_bus.az, sample_on_bus.ay, sample_on_bus.ax};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        compass_result_t want;
        angle_t          got_heading, got_pitch, got_roll;
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_stall = 0;
        end else if (m_tvalid && m_tready) begin
            {got_roll, got_pitch, got_heading} = m_tdata[3*ANGLE_BITS-1:0];
            if (compass_expected.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                want = compass_expected.pop_front();
                if (got_heading !== want.heading) begin
                    $error("heading: expected %0d, got %0d", want.heading, got_heading);
                    error_count++;
                end
                if (got_pitch !== want.pitch) begin
                    $error("pitch_angle: expected %0d, got %0d", want.pitch, got_pitch);
                    error_count++;
                end
                if (got_roll !== want.roll) begin
                    $error("roll_angle: expected %0d, got %0d", want.roll, got_roll);
                    error_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
            end
            checked_count++;
            if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
            out_stall = recv_burst ? 0 : $urandom_range(0, 4);
            m_tready <= (out_stall == 0);
        end else if (out_stall > 0) begin
            out_stall--;
            m_tready <= (out_stall == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else if (++idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_tilt_compensated_compass_top: errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAG_MIN:    mag_min = val;
            REG_MAG_MAX:    mag_max = val;
            REG_TILT_LIMIT: tilt_limit = val;
            default: ;
        endcase
    endtask

    task automatic set_window(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [31:0] tilt);
        write_reg(REG_MAG_MIN, lo);
        write_reg(REG_MAG_MAX, hi);
        write_reg(REG_TILT_LIMIT, tilt);
        setting_count++;
    endtask

    task automatic queue_sample(input int ax, input int ay, input int az,
                                input int mx, input int my, input int mz);
        smp_t s;
        s.ax = sample_t'(ax); s.ay = sample_t'(ay); s.az = sample_t'(az);
        s.mx = sample_t'(mx); s.my = sample_t'(my); s.mz = sample_t'(mz);
        pending_samples.push_back(s);
    endtask

    function automatic int rand_sign(input int v);
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    // mostly a gravity vector near upright, some steep tilts, some raw noise
    task automatic queue_random(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 60)
                queue_sample(rand_sign($urandom_range(0, 900)),
                             rand_sign($urandom_range(0, 900)),
                             -$urandom_range(2100, 3000),
                             $urandom, $urandom, $urandom);
            else if (k < 80)
                queue_sample(rand_sign($urandom_range(0, 2800)),
                             rand_sign($urandom_range(0, 2800)),
                             rand_sign($urandom_range(0, 2800)),
                             rand_sign($urandom_range(0, 4000)),
                             rand_sign($urandom_range(0, 4000)),
                             rand_sign($urandom_range(0, 4000)));
            else
                queue_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // sender holds off until the pipeline is empty
    task automatic drain;
        while (pending_samples.size() > 0 || s_tvalid || compass_expected.size() > 0)
            @(posedge aclk);
        repeat (DEPTH + 10) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mag_min = MAG_MIN_RST;
        mag_max = MAG_MAX_RST;
        tilt_limit = TILT_LIMIT_RST;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        sent_count = 0;
        checked_count = 0;
        error_count = 0;
        setting_count = 1;
        idle_cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset defaults: window bounds and extremes
        queue_sample(0, 0, -2048, 100, -200, 300);        // sum exactly at the minimum
        queue_sample(0, 0, -2047, 100, -200, 300);        // just below
        queue_sample(0, 0, -3072, -500, 700, 50);         // sum exactly at the maximum
        queue_sample(0, 0, -3073, -500, 700, 50);         // just above
        queue_sample(0, 0, 0, 0, 0, 0);                   // zero acceleration
        queue_sample(-32768, -32768, -32768, -32768, -32768, -32768);
        queue_sample(32767, 32767, 32767, 32767, 32767, 32767);
        queue_sample(2000, 0, -1500, 1000, 0, 0);         // steep pitch, tilt refused
        queue_sample(0, 0, -2509, -32768, 0, 0);          // field straight back
        queue_sample(0, 0, -2509, 32767, 32767, -32768);
        queue_sample(0, 0, -2509, 0, 0, 0);               // zero field vector
        queue_sample(300, -400, -2400, 0, -32768, 32767);
        drain();

        // everything passes the window, tilt limit at its top
        set_window(32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_sample(0, 0, 0, 1234, -4321, 77);           // zero gravity vector
        queue_sample(0, 0, 2500, 0, 0, 0);                // upside down, pitch near pi
        queue_sample(1, 0, 2500, 5, 5, 5);
        queue_sample(-1, 1, 2500, 5, 5, 5);
        queue_sample(-32768, -32768, 32767, 100, 100, 100);
        queue_sample(-32768, 32767, -32768, -9, 9, -9);
        queue_random(200);
        drain();

        // unused register index is ignored
        write_reg(REG_SPARE, $urandom);
        queue_random(150);
        drain();

        // nothing passes except a zero vector, tilt always refused
        set_window(32'd0, 32'd0, 32'd0);
        queue_sample(0, 0, 0, 321, 654, -987);
        queue_random(40);
        drain();

        // back to defaults, long random run
        set_window(MAG_MIN_RST, MAG_MAX_RST, TILT_LIMIT_RST);
        queue_random(450);
        drain();

        // random settings
        for (int ph = 0; ph < 3; ph++) begin
            set_window($urandom_range(0, 32'h0040_0000), $urandom_range(32'h0080_0000, 32'h4000_0000),
                       $urandom_range(0, 32'h8000_0000));
            write_reg(REG_SPARE, $urandom);
            queue_random(130);
            drain();
        end

        $display("sent %0d samples, checked %0d results over %0d register settings",
                 sent_count, checked_count, setting_count);
        if (error_count == 0 && compass_expected.size() == 0)
            $display("tb_tilt_compensated_compass_top: clean");
        else
            $display("tb_tilt_compensated_compass_top: errors");
        $finish;
    end

endmodule
